// ===== hw/rtl/cpms_pkg.sv =====
`default_nettype none
package cpms_pkg;
	localparam int PHASE_BITS_DEF = 32;
	localparam int SINE_ITER_DEF = 16;
	localparam int SW = 36;
	localparam logic signed [SW-1:0] CORDIC_X0 = 36'sd652032874;

	localparam logic [2:0] REG_WP = 3'd0;
	localparam logic [2:0] REG_WQ = 3'd1;
	localparam logic [2:0] REG_GAIN = 3'd2;
	localparam logic [2:0] REG_F1 = 3'd3;
	localparam logic [2:0] REG_F2 = 3'd4;
	localparam logic [2:0] REG_ORD = 3'd5;

	function automatic logic signed [SW-1:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 36'sd536870912;
			5'd1: atan_turn = 36'sd316933406;
			5'd2: atan_turn = 36'sd167458907;
			5'd3: atan_turn = 36'sd85004756;
			5'd4: atan_turn = 36'sd42667331;
			5'd5: atan_turn = 36'sd21354465;
			5'd6: atan_turn = 36'sd10679838;
			5'd7: atan_turn = 36'sd5340245;
			5'd8: atan_turn = 36'sd2670163;
			5'd9: atan_turn = 36'sd1335087;
			5'd10: atan_turn = 36'sd667544;
			5'd11: atan_turn = 36'sd333772;
			5'd12: atan_turn = 36'sd166886;
			5'd13: atan_turn = 36'sd83443;
			5'd14: atan_turn = 36'sd41722;
			5'd15: atan_turn = 36'sd20861;
			5'd16: atan_turn = 36'sd10430;
			5'd17: atan_turn = 36'sd5215;
			5'd18: atan_turn = 36'sd2608;
			5'd19: atan_turn = 36'sd1304;
			5'd20: atan_turn = 36'sd652;
			5'd21: atan_turn = 36'sd326;
			5'd22: atan_turn = 36'sd163;
			5'd23: atan_turn = 36'sd81;
			5'd24: atan_turn = 36'sd41;
			5'd25: atan_turn = 36'sd20;
			5'd26: atan_turn = 36'sd10;
			5'd27: atan_turn = 36'sd5;
			5'd28: atan_turn = 36'sd3;
			5'd29: atan_turn = 36'sd1;
			5'd30: atan_turn = 36'sd1;
			default: atan_turn = 36'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/coupled_phase_map_step.sv =====
`default_nettype none
// Coupled two-phase oscillator map.
// Request channel: in_valid/in_stall with kind, load_first, load_second.
// kind 0 loads both phases, kind 1 advances the map one step.
// Result channel: out_valid/out_stall with phase_first, phase_second; one
// result per request.
// Configuration through the APB port, registers at 4*i: weight_p, weight_q,
// coupling_gain, freq_first, freq_second, update_order. Write only when idle.
// A load result is valid the cycle after acceptance. A step runs the
// shared CORDIC twice (one per phase); each pass goes through difference,
// CORDIC start, SINE_ITERATIONS rotations, done, multiply and sum, and the
// step result is valid once the second pass has been summed.
// One request at a time: in_stall is high from acceptance until the result
// has been taken. A stalled result holds its value.
// Reset clears phases, registers and control.
module coupled_phase_map_step #(
	parameter int PHASE_BITS = cpms_pkg::PHASE_BITS_DEF,
	parameter int SINE_ITERATIONS = cpms_pkg::SINE_ITER_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic kind,
	input  wire logic [31:0] load_first,
	input  wire logic [31:0] load_second,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [31:0] phase_first,
	output logic [31:0] phase_second,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cpms_pkg::*;
	localparam int PB = PHASE_BITS;
	localparam int SH = 54 - PB;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIFF = 7'b0000010,
		S_SIN  = 7'b0000100,
		S_WAIT = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_SUM  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;
	state_t st_q;

	logic [15:0] wp_q, wq_q;
	logic [31:0] gain_q, f1_q, f2_q;
	logic ord_q;
	logic [PB-1:0] ph1_q, ph2_q, new1_q, diff_q;
	logic second_q;
	logic signed [SW-1:0] sin_q;
	logic signed [67:0] prod_q;
	logic cstart, cdone;
	logic signed [SW-1:0] csine;

	function automatic logic [PB-1:0] to_phase(input logic [31:0] v);
		logic [PB+31:0] w;
		w = {v, PB'(0)};
		to_phase = w[PB+31:32];
	endfunction
	function automatic logic [31:0] to_turn(input logic [PB-1:0] p);
		logic [PB+31:0] w;
		w = {p, 32'(0)};
		to_turn = w[PB+31:PB];
	endfunction

	logic [PB-1:0] own, other, src;
	logic [PB+15:0] mp, mq;
	logic signed [68:0] rnd;
	logic [PB-1:0] kick;
	always_comb begin
		own = second_q ? ph2_q : ph1_q;
		src = ord_q ? ph1_q : new1_q;
		other = second_q ? src : ph2_q;
		mp = (PB+16)'($signed(wp_q)) * (PB+16)'(other);
		mq = (PB+16)'($signed(wq_q)) * (PB+16)'(own);
		rnd = 69'(prod_q) + (69'(1) <<< (SH - 1));
		kick = PB'(rnd >>> SH);
	end

	assign cstart = (st_q == S_SIN);
	cpms_cordic #(.SINE_ITERATIONS(SINE_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart),
		.angle(to_turn(diff_q)), .done(cdone), .sine(csine));

	assign pready = 1'b1;
	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		unique case (paddr[4:2])
			REG_WP: prdata = 32'($signed(wp_q));
			REG_WQ: prdata = 32'($signed(wq_q));
			REG_GAIN: prdata = gain_q;
			REG_F1: prdata = f1_q;
			REG_F2: prdata = f2_q;
			REG_ORD: prdata = {31'd0, ord_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; wq_q <= '0; gain_q <= '0;
			f1_q <= '0; f2_q <= '0; ord_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_WP: wp_q <= pwdata[15:0];
				REG_WQ: wq_q <= pwdata[15:0];
				REG_GAIN: gain_q <= pwdata;
				REG_F1: f1_q <= pwdata;
				REG_F2: f2_q <= pwdata;
				REG_ORD: ord_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph1_q <= '0;
			ph2_q <= '0;
			second_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					if (!kind) begin
						ph1_q <= to_phase(load_first);
						ph2_q <= to_phase(load_second);
						st_q <= S_OUT;
					end else begin
						second_q <= 1'b0;
						st_q <= S_DIFF;
					end
				end
				S_DIFF: st_q <= S_SIN;
				S_SIN: st_q <= S_WAIT;
				S_WAIT: if (cdone) st_q <= S_MUL;
				S_MUL: st_q <= S_SUM;
				S_SUM: begin
					if (!second_q) begin
						second_q <= 1'b1;
						st_q <= S_DIFF;
					end else begin
						ph1_q <= new1_q;
						ph2_q <= ph2_q + to_phase(f2_q) + kick;
						st_q <= S_OUT;
					end
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DIFF) diff_q <= mp[PB-1:0] - mq[PB-1:0];
		if (cdone) sin_q <= csine;
		if (st_q == S_MUL) prod_q <= 68'($signed(gain_q)) * 68'(sin_q);
		if (st_q == S_SUM && !second_q) new1_q <= ph1_q + to_phase(f1_q) + kick;
	end

	assign phase_first = to_turn(ph1_q);
	assign phase_second = to_turn(ph2_q);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result pending while ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase_first))
		else $error("stalled result changed");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> st_q == S_WAIT) else $error("CORDIC done out of sequence");
endmodule
`default_nettype wire

// ===== hw/rtl/cpms_cordic.sv =====
`default_nettype none
module cpms_cordic #(
	parameter int SINE_ITERATIONS = cpms_pkg::SINE_ITER_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [31:0] angle,
	output logic done,
	output logic signed [cpms_pkg::SW-1:0] sine
);
	import cpms_pkg::*;
	localparam int CW = $clog2(SINE_ITERATIONS + 1);
	logic signed [SW-1:0] x_q, y_q, z_q, dx, dy;
	logic signed [SW-1:0] a, af;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	// fold into [-1/4, +1/4] turn
	always_comb begin
		a = SW'($signed(angle));
		if (a > (SW'(1) <<< 30)) af = (SW'(1) <<< 31) - a;
		else if (a < -(SW'(1) <<< 30)) af = -(SW'(1) <<< 31) - a;
		else af = a;
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(SINE_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= af;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_turn(5'(cnt_q));
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_turn(5'(cnt_q));
			end
		end
	end
	assign sine = y_q;
endmodule
`default_nettype wire
